FILE: sv/usm_pkg.sv
`default_nettype none
package usm_pkg;

   localparam int PIX_W      = 8;
   localparam int COL_W      = 14;   // holds a column up to the largest row length
   localparam int ROW_W      = 16;
   localparam int SLOT_W     = 3;    // ring of up to eight rows
   localparam int TAP_W      = 16;
   localparam int AMT_W      = 12;
   localparam int ACC_W      = 27;   // seven 8x16 products
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TAP_CENTER     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_ONE        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_TWO        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_THREE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARPEN_AMOUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS     = 3'd6;

   // One classified item: an optional byte store and an optional result job.
   typedef struct packed {
      logic              wr;
      logic [PIX_W-1:0]  pixel;
      logic [SLOT_W-1:0] wr_slot;
      logic [COL_W-1:0]  wr_col;
      logic              em;
      logic              last;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [SLOT_W-1:0] slot;
   } cmd_type;

   typedef struct packed {
      logic [TAP_W-1:0] center;
      logic [TAP_W-1:0] one;
      logic [TAP_W-1:0] two;
      logic [TAP_W-1:0] three;
   } taps_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_end;
   } rsp_type;

endpackage
`default_nettype wire

FILE: sv/unsharp_mask_separable_gaussian.sv
// Unsharp mask over interleaved 3-channel bytes in raster order, with a
// separable blur of KERNEL_TAPS taps (same-channel horizontal taps 3 bytes apart).
// Input queue: drive req_func/req_pixel_in and raise req_push; a transfer takes
// place on a clock edge with req_full low. Func 0 carries a source byte; after
// the frame's last byte send func 1 drain items to flush the lagging results.
// Result queue: while rsp_empty is low the oldest result sits on rsp_pixel_out
// and rsp_frame_end; raise rsp_pop to take it. rsp_frame_end marks the last
// byte of the frame, after which the block is ready for the next frame.
// The first result follows H*row_bytes + min(3H, row_bytes-1) items (H = taps/2).
// For each result the back end reads the T x T window (T = KERNEL_TAPS) one
// byte at a time from the row ring, each read followed by a multiply-accumulate,
// and takes no new item meanwhile. Store-only items are written as they are popped.
// A command queue of two lets the front keep accepting while the back works.
// A stalled receiver fills the two-entry result queue, then stalls the back,
// then the command queue, and finally raises req_full. Nothing is dropped.
// Reset clears all counters and queues and restores register defaults; the
// row ring is not cleared and is only read where written in the current frame.
// Writing row_bytes or frame_rows restarts the frame.
`default_nettype none
module unsharp_mask_separable_gaussian #(
   parameter int MAX_ROW_BYTES = 4096,
   parameter int KERNEL_TAPS   = 7
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_func,
   input  wire logic [7:0]  req_pixel_in,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_pixel_out,
   output logic             rsp_frame_end,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import usm_pkg::*;

   localparam int RB_W = $clog2(MAX_ROW_BYTES + 1);

   taps_type         taps_ff;
   logic [11:0]      amount_ff;
   logic [12:0]      row_bytes_ff;
   logic [15:0]      frame_rows_ff;
   logic [RB_W-1:0]  eff_rb;
   logic [15:0]      eff_rows;
   logic             restart;

   cmd_type          cmd_wr, cmd_rd;
   logic             cmd_push, cmd_pop, cmd_empty;
   rsp_type          rsp_wr, rsp_rd;
   logic             out_push, out_full;

   // Clamp geometry: zero reads as one, long rows are capped
   always_comb begin
      if (row_bytes_ff == '0) begin
         eff_rb = RB_W'(1);
      end else if (32'(row_bytes_ff) > 32'(MAX_ROW_BYTES)) begin
         eff_rb = RB_W'(MAX_ROW_BYTES);
      end else begin
         eff_rb = RB_W'(row_bytes_ff);
      end
      eff_rows = (frame_rows_ff == '0) ? 16'd1 : frame_rows_ff;
   end

   assign restart = csr_we && ((csr_index == CSR_ROW_BYTES) || (csr_index == CSR_FRAME_ROWS));

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff.center <= 16'd26156;
         taps_ff.one    <= 16'd15860;
         taps_ff.two    <= 16'd3539;
         taps_ff.three  <= 16'd290;
         amount_ff      <= 12'd128;
         row_bytes_ff   <= 13'd3072;
         frame_rows_ff  <= 16'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TAP_CENTER:     taps_ff.center <= csr_wdata;
            CSR_TAP_ONE:        taps_ff.one    <= csr_wdata;
            CSR_TAP_TWO:        taps_ff.two    <= csr_wdata;
            CSR_TAP_THREE:      taps_ff.three  <= csr_wdata;
            CSR_SHARPEN_AMOUNT: amount_ff      <= csr_wdata[11:0];
            CSR_ROW_BYTES:      row_bytes_ff   <= csr_wdata[12:0];
            CSR_FRAME_ROWS:     frame_rows_ff  <= csr_wdata;
            default: ;  // unknown index: drop the write
         endcase
      end
   end

   // Front: count positions, classify each item into store and result jobs
   usm_front #(
      .MAX_ROW_BYTES(MAX_ROW_BYTES),
      .KERNEL_TAPS  (KERNEL_TAPS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .eff_rb      (eff_rb),
      .eff_rows    (eff_rows),
      .req_push    (req_push),
      .req_func    (req_func),
      .req_pixel_in(req_pixel_in),
      .cmd_full    (req_full),
      .cmd_push    (cmd_push),
      .cmd_out     (cmd_wr)
   );

   // Command queue between front and back
   usm_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(2)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .data_in (cmd_wr),
      .full    (req_full),
      .pop     (cmd_pop),
      .data_out(cmd_rd),
      .empty   (cmd_empty)
   );

   // Back: store bytes in the row ring, walk the window, sharpen
   usm_back #(
      .MAX_ROW_BYTES(MAX_ROW_BYTES),
      .KERNEL_TAPS  (KERNEL_TAPS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .eff_rb   (eff_rb),
      .eff_rows (eff_rows),
      .taps     (taps_ff),
      .amount   (amount_ff),
      .cmd_empty(cmd_empty),
      .cmd_in   (cmd_rd),
      .cmd_pop  (cmd_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_data (rsp_wr)
   );

   // Result queue: holds finished bytes while the receiver stalls
   usm_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(2)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .data_in (rsp_wr),
      .full    (out_full),
      .pop     (rsp_pop),
      .data_out(rsp_rd),
      .empty   (rsp_empty)
   );

   assign rsp_pixel_out = rsp_rd.pixel;
   assign rsp_frame_end = rsp_rd.frame_end;

endmodule
`default_nettype wire

FILE: sv/usm_fifo.sv
`default_nettype none
module usm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] data_in,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] data_out,
   output logic                  empty
);

   localparam int PW  = $clog2(DEPTH);
   localparam int CTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CTW-1:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CTW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= data_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CTW'(DEPTH))
      else $error("fifo count beyond depth");
   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      (push && !full && !(pop && !empty)) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("fifo push lost");
   a_pop_shrinks : assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !(push && !full)) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("fifo pop lost");
`endif

endmodule
`default_nettype wire

FILE: sv/usm_front.sv
`default_nettype none
module usm_front #(
   parameter int MAX_ROW_BYTES = 4096,
   parameter int KERNEL_TAPS   = 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          restart,
   input  wire logic [$clog2(MAX_ROW_BYTES+1)-1:0] eff_rb,
   input  wire logic [15:0]                   eff_rows,
   input  wire logic                          req_push,
   input  wire logic                          req_func,
   input  wire logic [7:0]                    req_pixel_in,
   input  wire logic                          cmd_full,
   output logic                               cmd_push,
   output usm_pkg::cmd_type                   cmd_out
);
   import usm_pkg::*;

   localparam int HALF  = KERNEL_TAPS / 2;
   localparam int RING  = 2 * HALF + 2;
   localparam int CW    = $clog2(MAX_ROW_BYTES);
   localparam int RB_W  = $clog2(MAX_ROW_BYTES + 1);
   localparam int CNT_W = RB_W + ROW_W + 1;
   localparam int SW    = $clog2(RING);

   logic [CNT_W-1:0] item_count_ff, item_count_in, count_next, total, lag, look, rb_ext;
   logic [CW-1:0]    in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [SW-1:0]    in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic             accept, writing, ignore, emit, last;

   assign rb_ext     = CNT_W'(eff_rb);
   assign total      = rb_ext * CNT_W'(eff_rows);
   assign look       = (CNT_W'(3 * HALF) < rb_ext - 1'b1) ? CNT_W'(3 * HALF) : rb_ext - 1'b1;
   assign lag        = CNT_W'(HALF) * rb_ext + look;
   assign accept     = req_push && !cmd_full;
   assign writing    = item_count_ff < total;
   assign ignore     = writing && req_func;
   assign count_next = item_count_ff + 1'b1;
   assign emit       = count_next > lag;
   assign last       = (out_row_ff == eff_rows - 1'b1) && (CNT_W'(out_col_ff) == rb_ext - 1'b1);
   assign cmd_push   = accept && !ignore && (writing || emit);

   always_comb begin
      cmd_out         = '0;
      cmd_out.wr      = writing;
      cmd_out.pixel   = req_pixel_in;
      cmd_out.wr_slot = SLOT_W'(in_slot_ff);
      cmd_out.wr_col  = COL_W'(in_col_ff);
      cmd_out.em      = emit;
      cmd_out.last    = last;
      cmd_out.row     = out_row_ff;
      cmd_out.col     = COL_W'(out_col_ff);
      cmd_out.slot    = SLOT_W'(out_slot_ff);
   end

   always_comb begin
      item_count_in = item_count_ff;
      in_col_in     = in_col_ff;
      in_slot_in    = in_slot_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      out_slot_in   = out_slot_ff;
      if (restart) begin
         item_count_in = '0;
         in_col_in     = '0;
         in_slot_in    = '0;
         out_col_in    = '0;
         out_row_in    = '0;
         out_slot_in   = '0;
      end else if (accept && !ignore) begin
         item_count_in = count_next;
         if (writing) begin
            if (CNT_W'(in_col_ff) + 1'b1 >= rb_ext) begin
               in_col_in  = '0;
               in_slot_in = (in_slot_ff == SW'(RING - 1)) ? '0 : in_slot_ff + 1'b1;
            end else begin
               in_col_in = in_col_ff + 1'b1;
            end
         end
         if (emit) begin
            if (last) begin
               // frame done: start the next one from the top
               item_count_in = '0;
               in_col_in     = '0;
               in_slot_in    = '0;
               out_col_in    = '0;
               out_row_in    = '0;
               out_slot_in   = '0;
            end else if (CNT_W'(out_col_ff) + 1'b1 >= rb_ext) begin
               out_col_in  = '0;
               out_row_in  = out_row_ff + 1'b1;
               out_slot_in = (out_slot_ff == SW'(RING - 1)) ? '0 : out_slot_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= '0;
         in_col_ff     <= '0;
         in_slot_ff    <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         out_slot_ff   <= '0;
      end else begin
         item_count_ff <= item_count_in;
         in_col_ff     <= in_col_in;
         in_slot_ff    <= in_slot_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         out_slot_ff   <= out_slot_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/usm_back.sv
`default_nettype none
module usm_back #(
   parameter int MAX_ROW_BYTES = 4096,
   parameter int KERNEL_TAPS   = 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [$clog2(MAX_ROW_BYTES+1)-1:0] eff_rb,
   input  wire logic [15:0]                   eff_rows,
   input  wire usm_pkg::taps_type             taps,
   input  wire logic [11:0]                   amount,
   input  wire logic                          cmd_empty,
   input  wire usm_pkg::cmd_type              cmd_in,
   output logic                               cmd_pop,
   input  wire logic                          out_full,
   output logic                               out_push,
   output usm_pkg::rsp_type                   out_data
);
   import usm_pkg::*;

   localparam int HALF = KERNEL_TAPS / 2;
   localparam int RING = 2 * HALF + 2;
   localparam int DEPTH = RING * MAX_ROW_BYTES;
   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(MAX_ROW_BYTES);
   localparam int KW   = $clog2(KERNEL_TAPS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_MAC  = 3'd2;
   localparam logic [2:0] S_ROW  = 3'd3;
   localparam logic [2:0] S_ORD  = 3'd4;
   localparam logic [2:0] S_MUL  = 3'd5;
   localparam logic [2:0] S_SUB  = 3'd6;

   function automatic logic [TAP_W-1:0] tap_weight(input int off, input taps_type t);
      int d;
      logic [TAP_W-1:0] w;
      d = (off < 0) ? -off : off;
      if (d == 0) w = t.center;
      else if (d == 1) w = t.one;
      else if (d == 2) w = t.two;
      else w = t.three;
      return w;
   endfunction

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic             mem_we;

   logic [2:0]        state_ff, state_in;
   logic [KW-1:0]     kv_ff, kv_in, kh_ff, kh_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              last_ff, last_in;
   logic [ACC_W-1:0]  hsum_ff, hsum_in, vsum_ff, vsum_in;
   logic [20:0]       pos_ff, pos_in, neg_ff, neg_in, diff;
   logic [23:0]       h_prod, v_prod;
   logic [PIX_W-1:0]  hb, blur;
   logic [12:0]       gain;
   int                offv, offh, rv, sv, cv;

   assign hb     = (|hsum_ff[ACC_W-1:24]) ? 8'hFF : hsum_ff[23:16];
   assign blur   = (|vsum_ff[ACC_W-1:24]) ? 8'hFF : vsum_ff[23:16];
   assign h_prod = rd_data_ff * tap_weight(offh, taps);
   assign v_prod = hb * tap_weight(offv, taps);
   assign gain   = 13'(amount) + 13'd256;
   assign diff   = pos_ff - neg_ff;

   assign cmd_pop  = (state_ff == S_IDLE) && !cmd_empty;
   assign mem_we   = cmd_pop && cmd_in.wr;
   assign wr_addr  = AW'(int'(cmd_in.wr_slot) * MAX_ROW_BYTES + int'(cmd_in.wr_col));
   assign out_push = (state_ff == S_SUB) && !out_full;

   always_comb begin
      out_data.frame_end = last_ff;
      if (pos_ff <= neg_ff) begin
         out_data.pixel = '0;
      end else begin
         out_data.pixel = (|diff[20:16]) ? 8'hFF : diff[15:8];
      end
   end

   // window address with clamped row and column
   always_comb begin
      offv = int'(kv_ff) - HALF;
      offh = int'(kh_ff) - HALF;
      rv = int'(row_ff) + offv;
      if (rv < 0) rv = 0;
      if (rv > int'(eff_rows) - 1) rv = int'(eff_rows) - 1;
      sv = int'(slot_ff) + rv - int'(row_ff);
      if (sv < 0) sv = sv + RING;
      else if (sv >= RING) sv = sv - RING;
      cv = int'(col_ff) + 3 * offh;
      if (cv < 0) cv = 0;
      if (cv > int'(eff_rb) - 1) cv = int'(eff_rb) - 1;
      if (state_ff == S_ORD) begin
         sv = int'(slot_ff);
         cv = int'(col_ff);
      end
      rd_addr = AW'(sv * MAX_ROW_BYTES + cv);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= cmd_in.pixel;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      kv_in    = kv_ff;
      kh_in    = kh_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      slot_in  = slot_ff;
      last_in  = last_ff;
      hsum_in  = hsum_ff;
      vsum_in  = vsum_ff;
      pos_in   = pos_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_pop && cmd_in.em) begin
               row_in   = cmd_in.row;
               col_in   = CW'(cmd_in.col);
               slot_in  = cmd_in.slot;
               last_in  = cmd_in.last;
               kv_in    = '0;
               kh_in    = '0;
               hsum_in  = '0;
               vsum_in  = '0;
               state_in = S_RD;
            end
         end
         S_RD: state_in = S_MAC;
         S_MAC: begin
            hsum_in = hsum_ff + ACC_W'(h_prod);
            if (kh_ff == KW'(KERNEL_TAPS - 1)) begin
               state_in = S_ROW;
            end else begin
               kh_in    = kh_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_ROW: begin
            vsum_in = vsum_ff + ACC_W'(v_prod);
            hsum_in = '0;
            kh_in   = '0;
            if (kv_ff == KW'(KERNEL_TAPS - 1)) begin
               state_in = S_ORD;
            end else begin
               kv_in    = kv_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_ORD: state_in = S_MUL;
         S_MUL: begin
            pos_in   = gain * rd_data_ff;
            neg_in   = amount * blur;
            state_in = S_SUB;
         end
         S_SUB: begin
            if (!out_full) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kv_ff    <= '0;
         kh_ff    <= '0;
      end else begin
         state_ff <= state_in;
         kv_ff    <= kv_in;
         kh_ff    <= kh_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      col_ff  <= col_in;
      slot_ff <= slot_in;
      last_ff <= last_in;
      hsum_ff <= hsum_in;
      vsum_ff <= vsum_in;
      pos_ff  <= pos_in;
      neg_ff  <= neg_in;
   end

endmodule
`default_nettype wire
